### hdl/sbow_pkg.sv
`default_nettype none

package sbow_pkg;

    // Field widths fixed by the item format
    localparam int POS_BITS     = 32;
    localparam int RADIUS_BITS  = 31;
    localparam int TIME_BITS    = 31;
    localparam int ENTRY_BITS   = 32;

    // Default coordinate width (positions wrap modulo 2^COORD_BITS)
    localparam int COORD_BITS_DEF = 32;

    // Saturation value of the running entry time
    localparam logic [ENTRY_BITS-1:0] ENTRY_MAX = '1;

    // Depth of the job queue between front and back
    localparam int JOB_DEPTH = 2;

    // What the back end has to do for one axis
    typedef enum logic [2:0] {
        K_ENTER = 3'd0,   // approaching: entry and exit divisions
        K_EXIT  = 3'd1,   // inside and moving: exit division only
        K_HOLD  = 3'd2,   // inside and still: window unchanged
        K_MISS  = 3'd3    // separated and still, or already passed
    } axis_kind_t;

    // Control part of a queued axis job
    typedef struct packed {
        logic       first;
        logic       last;
        axis_kind_t kind;
    } job_ctl_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIFF,
        F_VEL,
        F_GAP,
        F_CLASS,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DISPATCH,
        B_DIV_ENTRY,
        B_DIV_EXIT,
        B_CHECK,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

### hdl/sbow_item_if.sv
`default_nettype none

interface sbow_item_if import sbow_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [POS_BITS-1:0]    first_pos_now;
    logic signed [POS_BITS-1:0]    first_pos_next;
    logic signed [POS_BITS-1:0]    second_pos_now;
    logic signed [POS_BITS-1:0]    second_pos_next;
    logic        [RADIUS_BITS-1:0] first_radius;
    logic        [RADIUS_BITS-1:0] second_radius;
    logic        [TIME_BITS-1:0]   first_time_left;
    logic        [TIME_BITS-1:0]   second_time_left;
    logic                          first_axis;
    logic                          last_axis;

    modport source (
        output valid, first_pos_now, first_pos_next, second_pos_now, second_pos_next,
               first_radius, second_radius, first_time_left, second_time_left,
               first_axis, last_axis,
        input  ready
    );

    modport sink (
        input  valid, first_pos_now, first_pos_next, second_pos_now, second_pos_next,
               first_radius, second_radius, first_time_left, second_time_left,
               first_axis, last_axis,
        output ready
    );
endinterface

interface sbow_result_if import sbow_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [TIME_BITS-1:0] overlap_start;
    logic [TIME_BITS-1:0] overlap_end;

    modport source (
        output valid, hit, overlap_start, overlap_end,
        input  ready
    );

    modport sink (
        input  valid, hit, overlap_start, overlap_end,
        output ready
    );
endinterface

`default_nettype wire

### hdl/sbow_front.sv
`default_nettype none

module sbow_front import sbow_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sbow_item_if.sink                  items,
    output logic                       job_valid,
    input  wire logic                  job_ready,
    output job_ctl_t                   job_ctl,
    output logic [TIME_BITS-1:0]       job_time_a,
    output logic [TIME_BITS-1:0]       job_time_b,
    output logic [COORD_BITS-1:0]      job_gap,
    output logic [COORD_BITS-1:0]      job_far,
    output logic [COORD_BITS-1:0]      job_speed
);

    localparam int CB = COORD_BITS;

    front_state_t state_reg, state_next;

    // Captured item
    logic [CB-1:0]          a_now_reg, a_next_reg, b_now_reg, b_next_reg;
    logic [RADIUS_BITS-1:0] ra_reg, rb_reg;
    logic [TIME_BITS-1:0]   ta_reg, tb_reg;
    logic                   first_reg, last_reg;

    // Intermediate values
    logic [CB-1:0] d_reg, dn_reg, r_reg;
    logic [CB-1:0] v_reg, r2_reg, nr2_reg;
    logic [CB-1:0] gap_reg, speed_reg;
    logic [CB-1:0] far_reg;
    axis_kind_t    kind_reg;
    axis_kind_t    kind_next;

    logic accept;

    assign accept = items.valid && items.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (items.valid)
                begin
                    state_next = F_DIFF;
                end
            end
            F_DIFF:  state_next = F_VEL;
            F_VEL:   state_next = F_GAP;
            F_GAP:   state_next = F_CLASS;
            F_CLASS: state_next = F_PUSH;
            F_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        items.ready = 1'b0;
        job_valid   = 1'b0;
        unique case (state_reg)
            F_IDLE:  items.ready = 1'b1;
            F_PUSH:  job_valid   = 1'b1;
            default:
            begin
                items.ready = 1'b0;
                job_valid   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Classify the axis from the relative gap and closing speed
    always_comb
    begin
        if (!gap_reg[CB-1])
        begin
            kind_next = (speed_reg == '0) ? K_MISS : K_ENTER;
        end
        else if ($signed(gap_reg) <= $signed(nr2_reg))
        begin
            kind_next = K_MISS;
        end
        else if (speed_reg == '0)
        begin
            kind_next = K_HOLD;
        end
        else
        begin
            kind_next = K_EXIT;
        end
    end

    // Datapath: one arithmetic step per state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_now_reg  <= CB'(items.first_pos_now);
            a_next_reg <= CB'(items.first_pos_next);
            b_now_reg  <= CB'(items.second_pos_now);
            b_next_reg <= CB'(items.second_pos_next);
            ra_reg     <= items.first_radius;
            rb_reg     <= items.second_radius;
            ta_reg     <= items.first_time_left;
            tb_reg     <= items.second_time_left;
            first_reg  <= items.first_axis;
            last_reg   <= items.last_axis;
        end
        if (state_reg == F_DIFF)
        begin
            d_reg  <= a_now_reg - b_now_reg;
            dn_reg <= a_next_reg - b_next_reg;
            r_reg  <= CB'({1'b0, ra_reg} + {1'b0, rb_reg});
        end
        if (state_reg == F_VEL)
        begin
            v_reg   <= dn_reg - d_reg;
            r2_reg  <= {r_reg[CB-2:0], 1'b0};
            nr2_reg <= '0 - {r_reg[CB-2:0], 1'b0};
        end
        if (state_reg == F_GAP)
        begin
            if (v_reg[CB-1])
            begin
                speed_reg <= '0 - v_reg;
                gap_reg   <= d_reg - r_reg;
            end
            else
            begin
                speed_reg <= v_reg;
                gap_reg   <= '0 - d_reg - r_reg;
            end
        end
        if (state_reg == F_CLASS)
        begin
            kind_reg <= kind_next;
            far_reg  <= gap_reg + r2_reg + speed_reg - CB'(1);
        end
    end

    assign job_ctl.first = first_reg;
    assign job_ctl.last  = last_reg;
    assign job_ctl.kind  = kind_reg;
    assign job_time_a    = ta_reg;
    assign job_time_b    = tb_reg;
    assign job_gap       = gap_reg;
    assign job_far       = far_reg;
    assign job_speed     = speed_reg;

endmodule

`default_nettype wire

### hdl/sbow_fifo.sv
`default_nettype none

module sbow_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/sbow_div.sv
`default_nettype none

module sbow_div #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   shifted, diff;

    // One restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff;
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hdl/sbow_back.sv
`default_nettype none

module sbow_back import sbow_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    output logic                       job_ready,
    input  wire job_ctl_t              job_ctl,
    input  wire logic [TIME_BITS-1:0]  job_time_a,
    input  wire logic [TIME_BITS-1:0]  job_time_b,
    input  wire logic [COORD_BITS-1:0] job_gap,
    input  wire logic [COORD_BITS-1:0] job_far,
    input  wire logic [COORD_BITS-1:0] job_speed,
    sbow_result_if.source              results
);

    localparam int CB = COORD_BITS;
    localparam int WW = (CB > ENTRY_BITS) ? CB : ENTRY_BITS;

    back_state_t state_reg, state_next;

    // Running window of the query
    logic [ENTRY_BITS-1:0] entry_reg;
    logic [TIME_BITS-1:0]  exit_reg;
    logic                  missed_reg;

    // Working copy of the current job
    job_ctl_t      ctl_reg;
    logic [CB-1:0] far_reg, speed_reg;
    logic [CB-1:0] gap_hold_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [TIME_BITS-1:0] start_reg, end_reg;

    // Divider hookup
    logic          div_start;
    logic [CB-1:0] div_dividend;
    logic          div_done;
    logic [CB-1:0] div_quo;
    logic [WW-1:0] quo_wide;
    logic          out_free;
    logic          emit_load;

    sbow_div #(
        .WIDTH (CB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (speed_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_wide  = WW'(div_quo);
    assign out_free  = !out_valid_reg || results.ready;
    assign emit_load = (state_reg == B_EMIT) && ctl_reg.last && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = B_DISPATCH;
                end
            end
            B_DISPATCH:
            begin
                if (missed_reg)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    unique case (ctl_reg.kind)
                        K_ENTER: state_next = B_DIV_ENTRY;
                        K_EXIT:  state_next = B_DIV_EXIT;
                        default: state_next = B_EMIT;
                    endcase
                end
            end
            B_DIV_ENTRY:
            begin
                if (div_done)
                begin
                    state_next = B_DIV_EXIT;
                end
            end
            B_DIV_EXIT:
            begin
                if (div_done)
                begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK: state_next = B_EMIT;
            B_EMIT:
            begin
                if (!ctl_reg.last || out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        job_ready    = 1'b0;
        div_start    = 1'b0;
        div_dividend = far_reg;
        unique case (state_reg)
            B_IDLE: job_ready = 1'b1;
            B_DISPATCH:
            begin
                if (!missed_reg && (ctl_reg.kind == K_ENTER))
                begin
                    div_start    = 1'b1;
                    div_dividend = gap_hold_reg;
                end
                else if (!missed_reg && (ctl_reg.kind == K_EXIT))
                begin
                    div_start = 1'b1;
                end
            end
            B_DIV_ENTRY: div_start = div_done;
            default:
            begin
                job_ready = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Take the job
    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            ctl_reg      <= job_ctl;
            gap_hold_reg <= job_gap;
            far_reg      <= job_far;
            speed_reg    <= job_speed;
        end
    end

    // Update the running window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg  <= '0;
            exit_reg   <= '0;
            missed_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid && job_ctl.first)
                    begin
                        entry_reg  <= '0;
                        exit_reg   <= (job_time_a < job_time_b) ? job_time_a : job_time_b;
                        missed_reg <= 1'b0;
                    end
                end
                B_DISPATCH:
                begin
                    if (!missed_reg && (ctl_reg.kind == K_MISS))
                    begin
                        missed_reg <= 1'b1;
                    end
                end
                B_DIV_ENTRY:
                begin
                    if (div_done)
                    begin
                        if (quo_wide > WW'(ENTRY_MAX))
                        begin
                            entry_reg <= ENTRY_MAX;
                        end
                        else if (quo_wide[ENTRY_BITS-1:0] > entry_reg)
                        begin
                            entry_reg <= quo_wide[ENTRY_BITS-1:0];
                        end
                    end
                end
                B_DIV_EXIT:
                begin
                    if (div_done && (quo_wide < WW'(exit_reg)))
                    begin
                        exit_reg <= quo_wide[TIME_BITS-1:0];
                    end
                end
                B_CHECK:
                begin
                    if (entry_reg >= {1'b0, exit_reg})
                    begin
                        missed_reg <= 1'b1;
                    end
                end
                default:
                begin
                    missed_reg <= missed_reg;
                end
            endcase
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            hit_reg   <= !missed_reg;
            start_reg <= missed_reg ? '0 : entry_reg[TIME_BITS-1:0];
            end_reg   <= missed_reg ? '0 : exit_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.hit           = hit_reg;
    assign results.overlap_start = start_reg;
    assign results.overlap_end   = end_reg;

endmodule

`default_nettype wire

### hdl/swept_box_overlap_window_unit.sv
`default_nettype none

// An axis still approaching needs an entry and an exit division in the back end, one inside
// and moving the exit division only, and the rest none. The back end takes one axis at a
// time through the shared radix-2 divider (one quotient bit a cycle); the front end takes one
// item at a time and runs ahead behind a two-entry job queue. A result not taken holds the
// back end.
// Reset clears the running entry time, exit time and miss flag and empties the queue.
module swept_box_overlap_window_unit import sbow_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sbow_item_if.sink     items,
    sbow_result_if.source results
);

    localparam int CB     = COORD_BITS;
    localparam int CTL_W  = $bits(job_ctl_t);
    localparam int JOB_W  = CTL_W + 2 * TIME_BITS + 3 * CB;

    logic                 f_valid, f_ready;
    job_ctl_t             f_ctl;
    logic [TIME_BITS-1:0] f_ta, f_tb;
    logic [CB-1:0]        f_gap, f_far, f_speed;

    logic                 b_valid, b_ready;
    job_ctl_t             b_ctl;
    logic [TIME_BITS-1:0] b_ta, b_tb;
    logic [CB-1:0]        b_gap, b_far, b_speed;
    logic [JOB_W-1:0]     q_in, q_out;

    sbow_front #(
        .COORD_BITS (CB)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job_ctl    (f_ctl),
        .job_time_a (f_ta),
        .job_time_b (f_tb),
        .job_gap    (f_gap),
        .job_far    (f_far),
        .job_speed  (f_speed)
    );

    // Pack the job for the queue
    assign q_in = {f_ctl, f_ta, f_tb, f_gap, f_far, f_speed};

    sbow_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    assign {b_ctl, b_ta, b_tb, b_gap, b_far, b_speed} = q_out;

    sbow_back #(
        .COORD_BITS (CB)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (b_valid),
        .job_ready  (b_ready),
        .job_ctl    (b_ctl),
        .job_time_a (b_ta),
        .job_time_b (b_tb),
        .job_gap    (b_gap),
        .job_far    (b_far),
        .job_speed  (b_speed),
        .results    (results)
    );

endmodule

`default_nettype wire
